/* rtl/irl_pkg.sv */
// Shared types and constants for the input run-length logger.
// Used by the cell, the row and the top level; no dependencies.
package irl_pkg;

    localparam int STICK_W   = 4;
    localparam int BUTTON_W  = 4;
    localparam int FRAMES_W  = 10;
    localparam int IDLE_W    = 16;
    localparam int INDEX_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CAP    = 2'd1;

    localparam logic [IDLE_W-1:0]   RESET_IDLE_TIMEOUT = 16'd1800;
    localparam logic [FRAMES_W-1:0] RESET_COUNT_CAP    = 10'd1000;

    typedef struct packed {
        logic [STICK_W-1:0]  stick;
        logic [BUTTON_W-1:0] buttons;
        logic [FRAMES_W-1:0] frames;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic wipe;
        logic load;
    } t_cell_ctl;

endpackage

/* rtl/irl_cell.sv */
// One storage cell of a shifting row: loads its neighbor's word or wipes.
// Depends on irl_pkg for the control struct.
module irl_cell
    import irl_pkg::*;
#(
    parameter int W = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cell_ctl    i_ctl,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q;
    logic [W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.load) begin
            n_q = i_ctl.wipe ? '0 : i_d;
        end else if (i_ctl.wipe) begin
            n_q = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/irl_row.sv */
// Row of irl_cell instances; cell 0 takes the head word, each other cell
// takes the word of the cell before it. Depends on irl_pkg and irl_cell.
module irl_row
    import irl_pkg::*;
#(
    parameter int W     = 4,
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cell_ctl    i_head_ctl,
    input  t_cell_ctl    i_tail_ctl,
    input  logic [W-1:0] i_head,
    output logic [W-1:0] o_q [DEPTH]
);

    irl_cell #(.W(W)) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (i_head_ctl),
        .i_d     (i_head),
        .o_q     (o_q[0])
    );

    for (genvar g = 1; g < DEPTH; g++) begin : g_cell
        irl_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_tail_ctl),
            .i_d     (o_q[g-1]),
            .o_q     (o_q[g])
        );
    end

endmodule

/* rtl/input_run_length_logger.sv */
// Top level of the input run-length logger: handshake, config registers,
// run/idle control and the log and trajectory rows. Depends on irl_pkg, irl_row.
// An accepted word's result word is registered and shows in the cycle after it is accepted.
// Throughput: one word per cycle while i_ready stays high; the output register frees as it is taken.
// Reset: synchronous, active low; log and trajectory clear at once, block
// inactive, registers at 1800 and 1000.
module input_run_length_logger
    import irl_pkg::*;
#(
    parameter int LOG_DEPTH  = 32,
    parameter int TRAJ_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [STICK_W-1:0]   i_stick_bits,
    input  logic [BUTTON_W-1:0]  i_button_bits,
    input  logic                 i_clear_req,
    input  logic [INDEX_W-1:0]   i_read_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STICK_W-1:0]   o_entry_stick,
    output logic [BUTTON_W-1:0]  o_entry_buttons,
    output logic [FRAMES_W-1:0]  o_entry_frames,
    output logic [STICK_W-1:0]   o_path_stick,
    output logic                 o_active,
    output logic [IDLE_W-1:0]    o_idle_frames,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int TW = (TRAJ_DEPTH > 1) ? $clog2(TRAJ_DEPTH) : 1;

    logic [IDLE_W-1:0]   r_idle_timeout;
    logic [FRAMES_W-1:0] r_count_cap;
    logic [IDLE_W-1:0]   r_idle;
    logic [IDLE_W-1:0]   n_idle;
    logic                r_active;
    logic                n_active;

    logic                r_valid;
    t_entry              r_entry;
    logic [STICK_W-1:0]  r_path;
    logic                r_out_active;
    logic [IDLE_W-1:0]   r_out_idle;

    t_entry              n_entry;
    logic [STICK_W-1:0]  n_path;

    logic                accept;
    logic                tick;
    logic                wipe;
    logic                push;
    logic                same;
    t_entry              head_old;
    t_entry              head_new;
    logic [IDLE_W-1:0]   idle_mid;
    logic                active_mid;

    logic [ENTRY_W-1:0]  log_q  [LOG_DEPTH];
    logic [STICK_W-1:0]  traj_q [TRAJ_DEPTH];
    t_cell_ctl           head_ctl;
    t_cell_ctl           log_ctl;
    t_cell_ctl           traj_ctl;
    logic [LW-1:0]       log_sel;
    logic [TW-1:0]       traj_sel;

    assign o_ready     = !r_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign tick        = accept && (i_cmd == CMD_TICK);
    assign o_cfg_ready = 1'b1;

    assign head_old = t_entry'(log_q[0]);
    assign wipe     = i_clear_req || (r_active && (r_idle >= r_idle_timeout));

    always_comb begin
        idle_mid   = wipe ? '0 : r_idle;
        active_mid = wipe ? i_clear_req : r_active;
        head_new   = wipe ? '0 : head_old;
        same       = (i_stick_bits == head_new.stick) && (i_button_bits == head_new.buttons);
        push       = !same;
        n_idle     = idle_mid;
        n_active   = active_mid;
        if (same) begin
            if ((i_stick_bits == '0) && (i_button_bits == '0) && active_mid
                && (idle_mid < r_idle_timeout)) begin
                n_idle = idle_mid + 1'b1;
            end
            if (head_new.frames < r_count_cap) begin
                head_new.frames = head_new.frames + 1'b1;
            end
        end else begin
            head_new.stick   = i_stick_bits;
            head_new.buttons = i_button_bits;
            head_new.frames  = FRAMES_W'(1);
            n_idle           = IDLE_W'(1);
            n_active         = 1'b1;
        end
    end

    assign head_ctl = '{wipe: 1'b0, load: tick};
    assign log_ctl  = '{wipe: tick && wipe, load: tick && push};
    assign traj_ctl = '{wipe: tick && wipe, load: tick};

    irl_row #(.W(ENTRY_W), .DEPTH(LOG_DEPTH)) u_log (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_ctl (head_ctl),
        .i_tail_ctl (log_ctl),
        .i_head     (ENTRY_W'(head_new)),
        .o_q        (log_q)
    );

    irl_row #(.W(STICK_W), .DEPTH(TRAJ_DEPTH)) u_traj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_ctl (head_ctl),
        .i_tail_ctl (traj_ctl),
        .i_head     (i_stick_bits),
        .o_q        (traj_q)
    );

    assign log_sel  = LW'(i_read_index);
    assign traj_sel = TW'(i_read_index);

    always_comb begin
        if (i_cmd == CMD_READ) begin
            n_entry = (32'(i_read_index) < LOG_DEPTH) ? t_entry'(log_q[log_sel]) : '0;
            n_path  = (32'(i_read_index) < TRAJ_DEPTH) ? traj_q[traj_sel] : '0;
        end else begin
            n_entry = head_new;
            n_path  = i_stick_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= RESET_IDLE_TIMEOUT;
            r_count_cap    <= RESET_COUNT_CAP;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDLE_TIMEOUT) begin
                r_idle_timeout <= i_cfg_data;
            end else if (i_cfg_index == CFG_COUNT_CAP) begin
                r_count_cap <= i_cfg_data[FRAMES_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle   <= '0;
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (tick) begin
                r_idle   <= n_idle;
                r_active <= n_active;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
            r_path  <= n_path;
            if (i_cmd == CMD_READ) begin
                r_out_active <= r_active;
                r_out_idle   <= r_active ? r_idle : '0;
            end else begin
                r_out_active <= n_active;
                r_out_idle   <= n_active ? n_idle : '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_entry_stick   = r_entry.stick;
    assign o_entry_buttons = r_entry.buttons;
    assign o_entry_frames  = r_entry.frames;
    assign o_path_stick    = r_path;
    assign o_active        = r_out_active;
    assign o_idle_frames   = r_out_idle;

endmodule
